### src/dedup_jump_history_defines.svh
// Assertion macros for the jump history block.
// Included by the modules that carry concurrent assertions; needs no package.
`ifndef DEDUP_JUMP_HISTORY_DEFINES_SVH
`define DEDUP_JUMP_HISTORY_DEFINES_SVH
`ifndef SYNTHESIS
`define DJH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DJH_ASSERT_IMPL(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define DJH_ASSERT(lbl, clk, rst, prop, msg)
`define DJH_ASSERT_IMPL(lbl, clk, rst, pre, post, msg)
`endif
`endif

### src/djh_pkg.sv
// Types and constants shared by the jump history block.
// No dependencies.
`timescale 1ns / 1ps
package djh_pkg;

   localparam int LINE_W = 31;

   localparam logic [1:0] FUNC_PUSH = 2'd0;
   localparam logic [1:0] FUNC_PREV = 2'd1;
   localparam logic [1:0] FUNC_NEXT = 2'd2;
   localparam logic [1:0] FUNC_NOP  = 2'd3;

   // register index as seen in paddr[2]
   localparam logic CSR_MAX_ENTRIES = 1'b0;

   localparam logic [7:0] RESET_MAX_ENTRIES = 8'd100;

   typedef struct packed {
      logic [1:0]        func;
      logic [LINE_W-1:0] line;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [LINE_W-1:0] target_line;
   } rsp_type;

endpackage

### src/dedup_jump_history.sv
// Top level of the jump history block: sequencer around one history memory.
// Depends on djh_pkg and dedup_jump_history_defines.svh.
`timescale 1ns / 1ps
`include "dedup_jump_history_defines.svh"
// Usage:
//   A command word (func, line) is taken when start is high and busy is low.
//   Push stores a line, removing an older copy of it and evicting one entry at
//   the limit; previous and next push the cursor line and then walk the list
//   for the nearest different line.
//   Each command gives exactly one result word on rsp_data, marked by a
//   single-cycle rsp_strobe; the receiver cannot stall, so the word must be
//   taken in that cycle.
//   The unused function code answers in the next cycle. Other commands step
//   through the history: each entry searched, each entry moved in a remove or
//   insert shift, and each entry walked is one visit. Each entry visit is one
//   read of the single history memory through its registered read port, then
//   a compare or a write. One command is in flight at a time; busy is high
//   while any command other than the unused function code runs.
//   Reset empties the history and sets max_entries to 100; the memory itself
//   is not cleared, since only stored entries are ever read.
//   max_entries is written over the APB-style port at byte address 0.
module dedup_jump_history
   import djh_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_data,
   output logic          rsp_strobe,
   output rsp_type       rsp_data,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [2:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   output logic          pready
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_SB_RD   = 4'd1;
   localparam logic [3:0] ST_SB_CMP  = 4'd2;
   localparam logic [3:0] ST_SF_RD   = 4'd3;
   localparam logic [3:0] ST_SF_CMP  = 4'd4;
   localparam logic [3:0] ST_RM_RD   = 4'd5;
   localparam logic [3:0] ST_RM_WR   = 4'd6;
   localparam logic [3:0] ST_EV      = 4'd7;
   localparam logic [3:0] ST_INS     = 4'd8;
   localparam logic [3:0] ST_INS_RD  = 4'd9;
   localparam logic [3:0] ST_INS_WR  = 4'd10;
   localparam logic [3:0] ST_NAV_RD  = 4'd11;
   localparam logic [3:0] ST_NAV_CMP = 4'd12;

   logic [LINE_W-1:0] mem [CAPACITY];

   logic [3:0]        state_ff, state_in;
   logic [1:0]        func_ff, func_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     cursor_ff, cursor_in;
   logic              evict_ff, evict_in;
   logic [7:0]        max_entries_ff;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [LINE_W-1:0] rd_data_ff;

   logic              rd_en, wr_en;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic [LINE_W-1:0] wr_data;
   logic [CW-1:0]     idx_inc, idx_dec, cursor_inc, cursor_dec, count_dec;
   logic [CW-1:0]     limit;
   logic              csr_write;

   assign idx_inc    = idx_ff + CW'(1);
   assign idx_dec    = idx_ff - CW'(1);
   assign cursor_inc = cursor_ff + CW'(1);
   assign cursor_dec = cursor_ff - CW'(1);
   assign count_dec  = count_ff - CW'(1);

   // clamp the limit to 1 .. CAPACITY
   always_comb begin
      if (max_entries_ff == 8'd0) begin
         limit = CW'(1);
      end else if (32'(max_entries_ff) > 32'(CAPACITY)) begin
         limit = CW'(CAPACITY);
      end else begin
         limit = CW'(max_entries_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      line_in       = line_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      evict_in      = evict_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_data       = rd_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in = req_data.func;
               line_in = req_data.line;
               idx_in  = cursor_ff;
               if (req_data.func == FUNC_NOP) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '0;
               end else begin
                  state_in = ST_SB_RD;
               end
            end
         end
         // back part, from its tail
         ST_SB_RD: begin
            if (idx_ff == '0) begin
               idx_in   = cursor_ff;
               state_in = ST_SF_RD;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_dec[AW-1:0];
               state_in = ST_SB_CMP;
            end
         end
         ST_SB_CMP: begin
            idx_in = idx_dec;
            if (rd_data_ff == line_ff) begin
               pos_in   = idx_dec;
               evict_in = 1'b0;
               state_in = ST_RM_RD;
            end else begin
               state_in = ST_SB_RD;
            end
         end
         // forward part, from its head
         ST_SF_RD: begin
            if (idx_ff >= count_ff) begin
               state_in = ST_EV;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[AW-1:0];
               state_in = ST_SF_CMP;
            end
         end
         ST_SF_CMP: begin
            if (rd_data_ff == line_ff) begin
               pos_in   = idx_ff;
               evict_in = 1'b0;
               state_in = ST_RM_RD;
            end else begin
               idx_in   = idx_inc;
               state_in = ST_SF_RD;
            end
         end
         // close the gap at pos: move each later entry down by one
         ST_RM_RD: begin
            if (idx_inc < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_inc[AW-1:0];
               state_in = ST_RM_WR;
            end else begin
               count_in = count_dec;
               if (pos_ff < cursor_ff) begin
                  cursor_in = cursor_dec;
               end
               state_in = evict_ff ? ST_INS : ST_EV;
            end
         end
         ST_RM_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[AW-1:0];
            idx_in   = idx_inc;
            state_in = ST_RM_RD;
         end
         ST_EV: begin
            if ((count_ff >= limit) && (count_ff != '0)) begin
               evict_in = 1'b1;
               state_in = ST_RM_RD;
               if (cursor_ff != '0) begin
                  pos_in = '0;
                  idx_in = '0;
               end else begin
                  pos_in = count_dec;
                  idx_in = count_dec;
               end
            end else begin
               state_in = ST_INS;
            end
         end
         ST_INS: begin
            if (count_ff >= CW'(CAPACITY)) begin
               if (func_ff == FUNC_PUSH) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '0;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_NAV_RD;
               end
            end else begin
               idx_in   = count_ff;
               state_in = ST_INS_RD;
            end
         end
         // open a slot at the cursor: move entries up by one, top first
         ST_INS_RD: begin
            if (idx_ff > cursor_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_dec[AW-1:0];
               state_in = ST_INS_WR;
            end else begin
               wr_en     = 1'b1;
               wr_addr   = cursor_ff[AW-1:0];
               wr_data   = line_ff;
               cursor_in = cursor_inc;
               count_in  = count_ff + CW'(1);
               if (func_ff == FUNC_PUSH) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '0;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_NAV_RD;
               end
            end
         end
         ST_INS_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[AW-1:0];
            idx_in   = idx_dec;
            state_in = ST_INS_RD;
         end
         ST_NAV_RD: begin
            if (func_ff == FUNC_PREV) begin
               if (cursor_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '0;
                  state_in      = ST_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = cursor_dec[AW-1:0];
                  state_in = ST_NAV_CMP;
               end
            end else begin
               if (cursor_ff >= count_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '0;
                  state_in      = ST_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = cursor_ff[AW-1:0];
                  state_in = ST_NAV_CMP;
               end
            end
         end
         ST_NAV_CMP: begin
            cursor_in = (func_ff == FUNC_PREV) ? cursor_dec : cursor_inc;
            if (rd_data_ff != line_ff) begin
               rsp_strobe_in           = 1'b1;
               rsp_data_in.found       = 1'b1;
               rsp_data_in.target_line = rd_data_ff;
               state_in                = ST_IDLE;
            end else begin
               state_in = ST_NAV_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         cursor_ff     <= '0;
         evict_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cursor_ff     <= cursor_in;
         evict_ff      <= evict_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      line_ff     <= line_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   // history memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= RESET_MAX_ENTRIES;
      end else if (csr_write && (paddr[2] == CSR_MAX_ENTRIES)) begin
         max_entries_ff <= pwdata[7:0];
      end
   end

   assign prdata     = (paddr[2] == CSR_MAX_ENTRIES) ? {24'd0, max_entries_ff} : 32'd0;
   assign pready     = 1'b1;
   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `DJH_ASSERT(a_cursor_in_list, clock, reset, cursor_ff <= count_ff, "cursor past stored count")
   `DJH_ASSERT(a_count_in_cap, clock, reset, count_ff <= CW'(CAPACITY), "count above capacity")
   `DJH_ASSERT_IMPL(a_no_rw_overlap, clock, reset, wr_en, !rd_en, "read and write in one cycle")
   `DJH_ASSERT_IMPL(a_result_at_idle, clock, reset, rsp_strobe_ff, state_ff == ST_IDLE, "result word while busy")
   `DJH_ASSERT_IMPL(a_miss_is_zero, clock, reset, rsp_strobe_ff && !rsp_data_ff.found, rsp_data_ff.target_line == '0, "miss with nonzero line")

endmodule
